// ----- hdl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int TAG_BITS = 16;
   localparam int PAY_BITS = 8;
   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spq_status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_STEP,
      SEQ_PLACE,
      SEQ_DONE
   } spq_state_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [PAY_BITS-1:0] payload;
   } spq_entry_type;

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] waddr;
      spq_entry_type       wdata;
      logic [IDX_BITS-1:0] raddr;
   } spq_ram_ctl_type;

endpackage

// ----- hdl/spq_if.sv -----
// request and response channel interfaces
interface spq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic signed [spq_pkg::TAG_BITS-1:0] new_priority;
   logic [spq_pkg::PAY_BITS-1:0]       new_payload;

   modport source (output valid, func, new_priority, new_payload, input ready);
   modport sink (input valid, func, new_priority, new_payload, output ready);
endinterface

interface spq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic signed [spq_pkg::TAG_BITS-1:0] removed_priority;
   logic [spq_pkg::PAY_BITS-1:0]        removed_payload;
   logic signed [spq_pkg::TAG_BITS-1:0] front_priority;
   logic [spq_pkg::PAY_BITS-1:0]        front_payload;
   logic signed [spq_pkg::TAG_BITS-1:0] rear_priority;
   logic [spq_pkg::PAY_BITS-1:0]        rear_payload;
   logic [spq_pkg::CNT_BITS-1:0]        entry_count;
   logic                                is_empty;

   modport source (output valid, status, removed_priority, removed_payload,
                   front_priority, front_payload, rear_priority, rear_payload,
                   entry_count, is_empty, input ready);
   modport sink (input valid, status, removed_priority, removed_payload,
                 front_priority, front_payload, rear_priority, rear_payload,
                 entry_count, is_empty, output ready);
endinterface

// ----- hdl/spq_ram.sv -----
// entry store: one write port, one registered read port
module spq_ram (
   input  logic                     clock,
   input  spq_pkg::spq_ram_ctl_type ctl,
   output spq_pkg::spq_entry_type   rdata
);

   spq_pkg::spq_entry_type mem [spq_pkg::CAPACITY];
   spq_pkg::spq_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata_ff <= mem[ctl.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/spq_seq.sv -----
// sequencer: walks the store one slot per step with a single tag compare
module spq_seq (
   input  logic                     clock,
   input  logic                     reset,
   spq_req_if.sink                  req,
   spq_rsp_if.source                rsp,
   output spq_pkg::spq_ram_ctl_type ram_ctl,
   input  spq_pkg::spq_entry_type   ram_rdata
);

   localparam logic [spq_pkg::CNT_BITS-1:0] CNT_ONE = spq_pkg::CNT_BITS'(1);
   localparam logic [spq_pkg::CNT_BITS-1:0] CNT_FULL = spq_pkg::CNT_BITS'(spq_pkg::CAPACITY);

   spq_pkg::spq_state_type          state_ff, state_in;
   logic [spq_pkg::CNT_BITS-1:0]    count_ff, count_in;
   logic [spq_pkg::CNT_BITS-1:0]    idx_ff, idx_in;
   logic                            op_ff, op_in;
   spq_pkg::spq_entry_type          new_ff, new_in;
   spq_pkg::spq_entry_type          front_ff, front_in;
   spq_pkg::spq_entry_type          rear_ff, rear_in;
   spq_pkg::spq_entry_type          rem_ff, rem_in;
   spq_pkg::spq_status_type         status_ff, status_in;

   logic                            out_valid_ff, out_valid_in;
   logic [1:0]                      out_status_ff, out_status_in;
   spq_pkg::spq_entry_type          out_rem_ff, out_rem_in;
   spq_pkg::spq_entry_type          out_front_ff, out_front_in;
   spq_pkg::spq_entry_type          out_rear_ff, out_rear_in;
   logic [spq_pkg::CNT_BITS-1:0]    out_count_ff, out_count_in;

   logic                            shift_up;
   logic [spq_pkg::CNT_BITS-1:0]    idx_dn;
   spq_pkg::spq_entry_type          zero_entry;

   assign zero_entry = '0;
   assign idx_dn     = idx_ff - CNT_ONE;
   // stored entry moves toward the rear while its tag is not below the new tag
   assign shift_up   = $signed(ram_rdata.tag) >= $signed(new_ff.tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::SEQ_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      new_ff        <= new_in;
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_rem_ff    <= out_rem_in;
      out_front_ff  <= out_front_in;
      out_rear_ff   <= out_rear_in;
      out_count_ff  <= out_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      new_in        = new_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_rem_in    = out_rem_ff;
      out_front_in  = out_front_ff;
      out_rear_in   = out_rear_ff;
      out_count_in  = out_count_ff;
      ram_ctl       = '0;
      req.ready     = 1'b0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         spq_pkg::SEQ_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in       = req.func;
               new_in.tag  = req.new_priority[spq_pkg::TAG_BITS-1:0];
               new_in.payload = req.new_payload;
               rem_in      = zero_entry;
               status_in   = spq_pkg::STATUS_DONE;
               state_in    = spq_pkg::SEQ_DONE;
               if (req.func == spq_pkg::FUNC_INSERT) begin
                  if (count_ff == CNT_FULL) begin
                     status_in = spq_pkg::STATUS_FULL;
                  end else if (count_ff == '0) begin
                     ram_ctl.we     = 1'b1;
                     ram_ctl.waddr  = '0;
                     ram_ctl.wdata  = new_in;
                     front_in       = new_in;
                     rear_in        = new_in;
                     count_in       = CNT_ONE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = spq_pkg::SEQ_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = spq_pkg::STATUS_EMPTY;
                  end else begin
                     rem_in = front_ff;
                     if (count_ff == CNT_ONE) begin
                        count_in = '0;
                     end else begin
                        idx_in   = CNT_ONE;
                        state_in = spq_pkg::SEQ_READ;
                     end
                  end
               end
            end
         end
         spq_pkg::SEQ_READ: begin
            // insert reads the slot below the hole, remove reads the slot above it
            if (op_ff == spq_pkg::FUNC_INSERT) begin
               ram_ctl.raddr = idx_dn[spq_pkg::IDX_BITS-1:0];
            end else begin
               ram_ctl.raddr = idx_ff[spq_pkg::IDX_BITS-1:0];
            end
            state_in = spq_pkg::SEQ_STEP;
         end
         spq_pkg::SEQ_STEP: begin
            ram_ctl.we = 1'b1;
            if (op_ff == spq_pkg::FUNC_INSERT) begin
               ram_ctl.waddr = idx_ff[spq_pkg::IDX_BITS-1:0];
               if (shift_up) begin
                  ram_ctl.wdata = ram_rdata;
                  idx_in        = idx_dn;
                  state_in      = (idx_dn == '0) ? spq_pkg::SEQ_PLACE : spq_pkg::SEQ_READ;
               end else begin
                  ram_ctl.wdata = new_ff;
                  if (idx_ff == count_ff) begin
                     rear_in = new_ff;
                  end
                  count_in = count_ff + CNT_ONE;
                  state_in = spq_pkg::SEQ_DONE;
               end
            end else begin
               ram_ctl.waddr = idx_dn[spq_pkg::IDX_BITS-1:0];
               ram_ctl.wdata = ram_rdata;
               if (idx_ff == CNT_ONE) begin
                  front_in = ram_rdata;
               end
               if (idx_ff == count_ff - CNT_ONE) begin
                  count_in = count_ff - CNT_ONE;
                  state_in = spq_pkg::SEQ_DONE;
               end else begin
                  idx_in   = idx_ff + CNT_ONE;
                  state_in = spq_pkg::SEQ_READ;
               end
            end
         end
         spq_pkg::SEQ_PLACE: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = '0;
            ram_ctl.wdata = new_ff;
            front_in      = new_ff;
            count_in      = count_ff + CNT_ONE;
            state_in      = spq_pkg::SEQ_DONE;
         end
         spq_pkg::SEQ_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_rem_in    = rem_ff;
               out_count_in  = count_ff;
               if (count_ff == '0) begin
                  out_front_in = zero_entry;
                  out_rear_in  = zero_entry;
               end else begin
                  out_front_in = front_ff;
                  out_rear_in  = rear_ff;
               end
               state_in = spq_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.status           = out_status_ff;
   assign rsp.removed_priority = out_rem_ff.tag;
   assign rsp.removed_payload  = out_rem_ff.payload;
   assign rsp.front_priority   = out_front_ff.tag;
   assign rsp.front_payload    = out_front_ff.payload;
   assign rsp.rear_priority    = out_rear_ff.tag;
   assign rsp.rear_payload     = out_rear_ff.payload;
   assign rsp.entry_count      = out_count_ff;
   assign rsp.is_empty         = (out_count_ff == '0);

endmodule

// ----- hdl/sorted_priority_queue_core.sv -----
// Sorted priority queue of 16 entries kept in ascending tag order in a store with one
// write port and one registered read port. An insert walks from the rear and moves each
// entry whose tag is equal or greater up one slot, reading and then writing each moved
// entry. A remove shifts the rest toward the front. Rejected requests (insert when full,
// remove when empty), the first insert and a remove of the last entry skip the walk.
// The response becomes valid in the same cycle that the next request can be taken and
// waits in an output register. A response still held there when the next one is ready
// stalls the sequencer until it is taken. No clearing pass follows reset.
module sorted_priority_queue_core (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   spq_pkg::spq_ram_ctl_type ram_ctl;
   spq_pkg::spq_entry_type   ram_rdata;

   spq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .ram_ctl   (ram_ctl),
      .ram_rdata (ram_rdata)
   );

   spq_ram u_ram (
      .clock (clock),
      .ctl   (ram_ctl),
      .rdata (ram_rdata)
   );

   // the sequencer is not ready in the cycle after it takes a request
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request taken while previous request still in progress");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == spq_pkg::STATUS_FULL
      |-> rsp.entry_count == spq_pkg::CNT_BITS'(spq_pkg::CAPACITY))
      else $error("insert dropped while queue not full");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == spq_pkg::STATUS_EMPTY
      |-> rsp.is_empty && rsp.removed_priority == '0 && rsp.removed_payload == '0)
      else $error("remove on empty queue reported data");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.we |-> !(req.ready && !req.valid))
      else $error("store written while sequencer idle");

endmodule
